/* hw/rtl/fixed_block_pool_allocator_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the fixed block pool allocator
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBPA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Types, codes and constants shared by the allocator modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int ADDR_W         = 32;
  localparam int CNT_W          = 9;
  localparam int STRIDE_W       = 17;
  localparam int ALIGN_W        = 4;
  localparam int DEF_MAX_BLOCKS = 256;

  localparam logic [STRIDE_W-1:0] MAX_BYTES      = 17'd65536;
  localparam logic [ALIGN_W-1:0]  MAX_ALIGN_LOG2 = 4'd12;

  localparam logic [ADDR_W-1:0]   RST_BASE  = '0;
  localparam logic [STRIDE_W-1:0] RST_BYTES = 17'd64;
  localparam logic [ALIGN_W-1:0]  RST_ALIGN = 4'd4;
  localparam logic [CNT_W-1:0]    RST_COUNT = '0;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REFILL = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_REJECTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_BASE  = 2'd0,
    CFG_BYTES = 2'd1,
    CFG_ALIGN = 2'd2,
    CFG_COUNT = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_FREE,
    S_FILL,
    S_RESULT
  } fsm_state_e;

  typedef struct packed {
    op_e               operation;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    status_e           status;
    logic [CNT_W-1:0]  free_count;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic pop;
    logic res_empty;
    logic calc_end;
    logic free_chk;
    logic fill_start;
    logic fill_step;
    logic capture;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic stack_empty;
    logic fill_done;
    logic out_free;
  } dp_sts_t;

endpackage

/* hw/rtl/fixed_block_pool_allocator_core.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator core
// Hands out and takes back equal-sized blocks through a last-in-first-out
// free stack of block addresses.
//
//   channel  ports                                   beat
//   input    in_valid, in_ready, in_data             operation, address
//   result   out_valid, out_ready, out_data          block_address, status,
//                                                    free_count
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  one register write
//
// One operation is in flight at a time. Allocate runs EXEC, READ, RESULT;
// free EXEC, FREE, RESULT; an allocate on an empty pool and the unused code
// EXEC, RESULT; refill EXEC, then FILL until the saturated block count is
// written, then RESULT. The result register lets the next beat be accepted
// while a result waits; that beat stalls in RESULT until the register is
// free. Reset is synchronous and leaves the free stack empty.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = rst_n;

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* hw/rtl/fbpa_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/fbpa_ctrl.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator controller
// Sequences one operation at a time and issues commands to the datapath.
// ----------------------------------------------------------------------------
module fbpa_ctrl import fbpa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  fsm_state_e state_r;
  fsm_state_e state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_ALLOC: begin
            if (sts.stack_empty) begin
              cmd.res_empty = 1'b1;
              state_nxt     = S_RESULT;
            end else begin
              cmd.pop   = 1'b1;
              state_nxt = S_READ;
            end
          end
          OP_FREE: begin
            cmd.calc_end = 1'b1;
            state_nxt    = S_FREE;
          end
          OP_REFILL: begin
            cmd.fill_start = 1'b1;
            state_nxt      = S_FILL;
          end
          default: begin
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_FREE: begin
        cmd.free_chk = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_FILL: begin
        if (sts.fill_done) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/fbpa_dp.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator datapath
// Configuration registers, stride and range logic, free stack and result
// register.
// ----------------------------------------------------------------------------
module fbpa_dp import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  logic              out_ready,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts
);

  localparam int DEPTH_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int PROD_W  = STRIDE_W + CNT_W;
  localparam int END_W   = ADDR_W + 2;

  logic [ADDR_W-1:0]   base_r;
  logic [STRIDE_W-1:0] bytes_r;
  logic [ALIGN_W-1:0]  align_r;
  logic [CNT_W-1:0]    count_r;

  logic [DEPTH_W-1:0]  depth_r;
  logic [CNT_W-1:0]    fill_idx_r;
  logic                out_valid_r;

  op_e                 op_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [ADDR_W-1:0]   res_addr_r;
  status_e             res_status_r;
  logic [PROD_W-1:0]   prod_r;
  logic [ADDR_W-1:0]   fill_acc_r;
  out_item_t           out_data_r;

  logic [STRIDE_W-1:0] size_clamp;
  logic [ALIGN_W-1:0]  lg;
  logic [STRIDE_W:0]   al_mask;
  logic [STRIDE_W:0]   rounded;
  logic [STRIDE_W-1:0] stride;
  logic [CNT_W-1:0]    eff_cnt;
  logic [END_W-1:0]    end_addr;
  logic                in_pool;
  logic                full;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ADDR_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ADDR_W-1:0]   ram_rdata;

  always_comb begin
    if (bytes_r == '0) begin
      size_clamp = STRIDE_W'(1);
    end else if (bytes_r > MAX_BYTES) begin
      size_clamp = MAX_BYTES;
    end else begin
      size_clamp = bytes_r;
    end
    lg       = (align_r > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : align_r;
    al_mask  = ((STRIDE_W + 1)'(1) << lg) - (STRIDE_W + 1)'(1);
    rounded  = ({1'b0, size_clamp} + al_mask) & ~al_mask;
    stride   = rounded[STRIDE_W-1:0];
    eff_cnt  = (32'(count_r) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_r;
    end_addr = {2'b00, base_r} + END_W'(prod_r);
    in_pool  = (addr_r != '0) && (addr_r >= base_r) && ({2'b00, addr_r} < end_addr);
    full     = (32'(depth_r) >= 32'(MAX_BLOCKS));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(depth_r);
    ram_wdata = addr_r;
    ram_re    = cmd.pop;
    ram_raddr = IDX_W'(depth_r - DEPTH_W'(1));
    if (cmd.free_chk && in_pool && !full) begin
      ram_we = 1'b1;
    end
    if (cmd.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(fill_idx_r);
      ram_wdata = fill_acc_r;
    end
  end

  fbpa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_BLOCKS),
    .AW    (IDX_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= RST_BASE;
      bytes_r     <= RST_BYTES;
      align_r     <= RST_ALIGN;
      count_r     <= RST_COUNT;
      depth_r     <= '0;
      fill_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BASE:  base_r  <= cfg_data;
          CFG_BYTES: bytes_r <= cfg_data[STRIDE_W-1:0];
          CFG_ALIGN: align_r <= cfg_data[ALIGN_W-1:0];
          CFG_COUNT: count_r <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.pop) begin
        depth_r <= depth_r - DEPTH_W'(1);
      end else if (cmd.free_chk && in_pool && !full) begin
        depth_r <= depth_r + DEPTH_W'(1);
      end else if (cmd.fill_start) begin
        depth_r <= '0;
      end else if (cmd.fill_step) begin
        depth_r <= DEPTH_W'(fill_idx_r) + DEPTH_W'(1);
      end
      if (cmd.fill_start) begin
        fill_idx_r <= '0;
      end else if (cmd.fill_step) begin
        fill_idx_r <= fill_idx_r + CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= in_data.operation;
      addr_r       <= in_data.address;
      res_addr_r   <= '0;
      res_status_r <= ST_OK;
    end
    if (cmd.res_empty) begin
      res_status_r <= ST_EMPTY;
    end
    if (cmd.calc_end) begin
      prod_r <= PROD_W'(stride) * PROD_W'(eff_cnt);
    end
    if (cmd.free_chk) begin
      if (!in_pool) begin
        res_status_r <= ST_REJECTED;
      end else if (full) begin
        res_status_r <= ST_FULL;
      end
    end
    if (cmd.capture) begin
      res_addr_r <= ram_rdata;
    end
    if (cmd.fill_start) begin
      fill_acc_r <= base_r;
    end else if (cmd.fill_step) begin
      fill_acc_r <= fill_acc_r + ADDR_W'(stride);
    end
    if (cmd.emit) begin
      out_data_r.block_address <= res_addr_r;
      out_data_r.status        <= res_status_r;
      out_data_r.free_count    <= CNT_W'(depth_r);
    end
  end

  assign sts.op          = op_r;
  assign sts.stack_empty = (depth_r == '0);
  assign sts.fill_done   = (fill_idx_r == eff_cnt);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/fbpa_checker.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator checker
// Port-level assertions, bound to the allocator core.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_core_macros.svh"

module fbpa_checker import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `FBPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped before it was taken")
  `FBPA_ASSERT_SAME(a_addr_only_ok, out_valid && (out_data.status != ST_OK), out_data.block_address == '0, "address returned with a failing status")
  `FBPA_ASSERT_SAME(a_count_bound, out_valid, 32'(out_data.free_count) <= 32'(MAX_BLOCKS), "free count beyond pool capacity")
  `FBPA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second beat taken while an operation is in flight")

endmodule

bind fixed_block_pool_allocator_core fbpa_checker #(
  .MAX_BLOCKS (MAX_BLOCKS)
) u_fbpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
